### rtl/nearest_neighbor_image_rotator_macros.svh
// Assertion macros for the nearest neighbor image rotator.
`ifndef NEAREST_NEIGHBOR_IMAGE_ROTATOR_MACROS_SVH
`define NEAREST_NEIGHBOR_IMAGE_ROTATOR_MACROS_SVH

// Check that cons holds whenever ante holds, outside reset.
`define NNIR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rotator port check failed");

// Check that expr holds at every clock edge outside reset.
`define NNIR_ASSERT_ALWAYS(label, clk, rst, expr) \
   `NNIR_ASSERT_IMPL(label, clk, rst, 1'b1, expr)

`endif

### rtl/nnir_pkg.sv
// Shared types and constants of the nearest neighbor image rotator.
package nnir_pkg;

   localparam int MAX_SIDE_DEF       = 512;
   localparam int COEF_FRAC_BITS_DEF = 14;

   localparam int ROW_W   = 10;
   localparam int COL_W   = 10;
   localparam int PIX_W   = 24;
   localparam int SRC_W   = 10;
   localparam int OUT_W   = 11;
   localparam int COEF_W  = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int RSP_LATENCY = 6;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUT_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_COEF   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_COEF   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_MODE = 3'd6;

   localparam logic [SRC_W-1:0]  SRC_WIDTH_RST  = 10'd512;
   localparam logic [SRC_W-1:0]  SRC_HEIGHT_RST = 10'd512;
   localparam logic [OUT_W-1:0]  OUT_WIDTH_RST  = 11'd724;
   localparam logic [OUT_W-1:0]  OUT_HEIGHT_RST = 11'd724;
   localparam logic [COEF_W-1:0] COS_COEF_RST   = 16'd11585;
   localparam logic [COEF_W-1:0] SIN_COEF_RST   = 16'd11585;
   localparam logic              COLOR_MODE_RST = 1'b0;

   localparam logic [PIX_W-1:0] WHITE_8  = 24'h0000FF;
   localparam logic [PIX_W-1:0] WHITE_24 = 24'hFFFFFF;

   typedef struct packed {
      logic             opcode;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             is_fill;
   } rsp_type;

endpackage

### rtl/nnir_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module nnir_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/nearest_neighbor_image_rotator.sv
// Nearest neighbor image rotator: frame store, back-mapping pipeline and result stage.
//
// The block takes one item per clock and busy stays low, so start may be held high
// every cycle. A write item passes stages 1 to 4, then stores its source pixel if it
// lies inside the source frame; a read item maps the output position back through a
// six-stage pipeline (position offsets, four parallel coefficient multipliers,
// the two mapped sums, truncation, one access of the frame store, then the result
// register); its result appears on rsp_valid and rsp_payload for one cycle, with no
// way to hold it off. Items are served strictly in order, at most one frame store
// access per item, so a read always sees every earlier write. The frame store is a
// single memory of MAX_SIDE * MAX_SIDE pixels of 24 bits, addressed
// row * MAX_SIDE + col; it is not cleared after reset, so a pixel that was never
// written reads back as any value. Configuration writes on the csr_ port are always
// ready and must be issued only while no item is in flight.
module nearest_neighbor_image_rotator #(
   parameter int MAX_SIDE       = nnir_pkg::MAX_SIDE_DEF,
   parameter int COEF_FRAC_BITS = nnir_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  nnir_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   output nnir_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [nnir_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [nnir_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import nnir_pkg::*;

   localparam int POS_W  = 12;
   localparam int PROD_W = POS_W + COEF_W;
   localparam int OFF_W  = SRC_W + 1 + COEF_FRAC_BITS;
   localparam int SUM_W  = ((PROD_W + 1) > (OFF_W + 1) ? (PROD_W + 1) : (OFF_W + 1)) + 1;
   localparam int SHIFT  = COEF_FRAC_BITS + 1;
   localparam int Q_W    = SUM_W - SHIFT;
   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W  = $clog2(MAX_SIDE);
   localparam logic signed [SUM_W-1:0] BIAS = SUM_W'((64'd1 << SHIFT) - 64'd1);

   // configuration
   logic [SRC_W-1:0]         src_width_ff;
   logic [SRC_W-1:0]         src_height_ff;
   logic [OUT_W-1:0]         out_width_ff;
   logic [OUT_W-1:0]         out_height_ff;
   logic signed [COEF_W-1:0] cos_coef_ff;
   logic signed [COEF_W-1:0] sin_coef_ff;
   logic                     color_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SRC_WIDTH_RST;
         src_height_ff <= SRC_HEIGHT_RST;
         out_width_ff  <= OUT_WIDTH_RST;
         out_height_ff <= OUT_HEIGHT_RST;
         cos_coef_ff   <= COS_COEF_RST;
         sin_coef_ff   <= SIN_COEF_RST;
         color_mode_ff <= COLOR_MODE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata[SRC_W-1:0];
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata[SRC_W-1:0];
            CSR_OUT_WIDTH:  out_width_ff  <= csr_wdata[OUT_W-1:0];
            CSR_OUT_HEIGHT: out_height_ff <= csr_wdata[OUT_W-1:0];
            CSR_COS_COEF:   cos_coef_ff   <= csr_wdata[COEF_W-1:0];
            CSR_SIN_COEF:   sin_coef_ff   <= csr_wdata[COEF_W-1:0];
            CSR_COLOR_MODE: color_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   logic [SRC_W-1:0] eff_w;
   logic [SRC_W-1:0] eff_h;
   logic [PIX_W-1:0] pix_mask;
   logic [OUT_W-1:0] h_plus1;
   logic [OUT_W-1:0] w_plus1;
   logic [OFF_W-1:0] off_h;
   logic [OFF_W-1:0] off_w;

   assign eff_w    = (src_width_ff > MAX_SIDE) ? SRC_W'(MAX_SIDE) : src_width_ff;
   assign eff_h    = (src_height_ff > MAX_SIDE) ? SRC_W'(MAX_SIDE) : src_height_ff;
   assign pix_mask = color_mode_ff ? WHITE_24 : WHITE_8;
   assign h_plus1  = {1'b0, src_height_ff} + 11'd1;
   assign w_plus1  = {1'b0, src_width_ff} + 11'd1;
   assign off_h    = {h_plus1, {COEF_FRAC_BITS{1'b0}}};
   assign off_w    = {w_plus1, {COEF_FRAC_BITS{1'b0}}};

   // stage 1: transfer and half-pixel offsets
   logic                    s1_valid_ff;
   logic                    s1_op_ff;
   logic [ROW_W-1:0]        s1_row_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic [PIX_W-1:0]        s1_pix_ff;
   logic signed [POS_W-1:0] s1_xh_ff;
   logic signed [POS_W-1:0] s1_yh_ff;
   logic signed [POS_W-1:0] s1_xh_in;
   logic signed [POS_W-1:0] s1_yh_in;

   assign s1_xh_in = $signed({1'b0, req_payload.row, 1'b0}) - $signed({1'b0, out_height_ff});
   assign s1_yh_in = $signed({1'b0, out_width_ff}) - $signed({1'b0, req_payload.col, 1'b0});

   // stage 2: coefficient products
   logic                     s2_valid_ff;
   logic                     s2_op_ff;
   logic [ROW_W-1:0]         s2_row_ff;
   logic [COL_W-1:0]         s2_col_ff;
   logic [PIX_W-1:0]         s2_pix_ff;
   logic signed [PROD_W-1:0] s2_xc_ff;
   logic signed [PROD_W-1:0] s2_ys_ff;
   logic signed [PROD_W-1:0] s2_xs_ff;
   logic signed [PROD_W-1:0] s2_yc_ff;
   logic signed [PROD_W-1:0] s2_xc_in;
   logic signed [PROD_W-1:0] s2_ys_in;
   logic signed [PROD_W-1:0] s2_xs_in;
   logic signed [PROD_W-1:0] s2_yc_in;

   assign s2_xc_in = s1_xh_ff * cos_coef_ff;
   assign s2_ys_in = s1_yh_ff * sin_coef_ff;
   assign s2_xs_in = s1_xh_ff * sin_coef_ff;
   assign s2_yc_in = s1_yh_ff * cos_coef_ff;

   // stage 3: mapped sums
   logic                    s3_valid_ff;
   logic                    s3_op_ff;
   logic [ROW_W-1:0]        s3_row_ff;
   logic [COL_W-1:0]        s3_col_ff;
   logic [PIX_W-1:0]        s3_pix_ff;
   logic signed [SUM_W-1:0] s3_ni_ff;
   logic signed [SUM_W-1:0] s3_nj_ff;
   logic signed [SUM_W-1:0] s3_ni_in;
   logic signed [SUM_W-1:0] s3_nj_in;

   assign s3_ni_in = SUM_W'(s2_xc_ff) - SUM_W'(s2_ys_ff) + $signed(SUM_W'(off_h));
   assign s3_nj_in = $signed(SUM_W'(off_w)) - (SUM_W'(s2_xs_ff) + SUM_W'(s2_yc_ff));

   // stage 4: truncate toward zero
   logic                    s4_valid_ff;
   logic                    s4_op_ff;
   logic [ROW_W-1:0]        s4_row_ff;
   logic [COL_W-1:0]        s4_col_ff;
   logic [PIX_W-1:0]        s4_pix_ff;
   logic signed [Q_W-1:0]   s4_qi_ff;
   logic signed [Q_W-1:0]   s4_qj_ff;
   logic signed [SUM_W-1:0] ni_biased;
   logic signed [SUM_W-1:0] nj_biased;
   logic signed [Q_W-1:0]   s4_qi_in;
   logic signed [Q_W-1:0]   s4_qj_in;

   assign ni_biased = s3_ni_ff + (s3_ni_ff[SUM_W-1] ? BIAS : '0);
   assign nj_biased = s3_nj_ff + (s3_nj_ff[SUM_W-1] ? BIAS : '0);
   assign s4_qi_in  = Q_W'(ni_biased >>> SHIFT);
   assign s4_qj_in  = Q_W'(nj_biased >>> SHIFT);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= req_payload.opcode;
      s1_row_ff <= req_payload.row;
      s1_col_ff <= req_payload.col;
      s1_pix_ff <= req_payload.pixel_in;
      s1_xh_ff  <= s1_xh_in;
      s1_yh_ff  <= s1_yh_in;

      s2_op_ff  <= s1_op_ff;
      s2_row_ff <= s1_row_ff;
      s2_col_ff <= s1_col_ff;
      s2_pix_ff <= s1_pix_ff;
      s2_xc_ff  <= s2_xc_in;
      s2_ys_ff  <= s2_ys_in;
      s2_xs_ff  <= s2_xs_in;
      s2_yc_ff  <= s2_yc_in;

      s3_op_ff  <= s2_op_ff;
      s3_row_ff <= s2_row_ff;
      s3_col_ff <= s2_col_ff;
      s3_pix_ff <= s2_pix_ff;
      s3_ni_ff  <= s3_ni_in;
      s3_nj_ff  <= s3_nj_in;

      s4_op_ff  <= s3_op_ff;
      s4_row_ff <= s3_row_ff;
      s4_col_ff <= s3_col_ff;
      s4_pix_ff <= s3_pix_ff;
      s4_qi_ff  <= s4_qi_in;
      s4_qj_ff  <= s4_qj_in;
   end

   // frame store access
   logic              wr_ok;
   logic              in_frame;
   logic              ram_wr_en;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  wr_row_idx;
   logic [IDX_W-1:0]  wr_col_idx;
   logic [IDX_W-1:0]  rd_row_idx;
   logic [IDX_W-1:0]  rd_col_idx;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [PIX_W-1:0]  ram_rd_data;

   assign wr_ok    = (s4_row_ff < eff_h) && (s4_col_ff < eff_w);
   assign in_frame = !s4_qi_ff[Q_W-1] && (s4_qi_ff < $signed(Q_W'(eff_h)))
                  && !s4_qj_ff[Q_W-1] && (s4_qj_ff < $signed(Q_W'(eff_w)));

   assign ram_wr_en = s4_valid_ff && (s4_op_ff == OP_WRITE) && wr_ok;
   assign ram_rd_en = s4_valid_ff && (s4_op_ff == OP_READ) && in_frame;

   assign wr_row_idx = IDX_W'(s4_row_ff);
   assign wr_col_idx = IDX_W'(s4_col_ff);
   assign rd_row_idx = IDX_W'(s4_qi_ff);
   assign rd_col_idx = IDX_W'(s4_qj_ff);
   assign wr_addr    = ADDR_W'(wr_row_idx * MAX_SIDE) + ADDR_W'(wr_col_idx);
   assign rd_addr    = ADDR_W'(rd_row_idx * MAX_SIDE) + ADDR_W'(rd_col_idx);

   nnir_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr),
      .wr_data (s4_pix_ff & pix_mask),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   // stage 5: read data returns; stage 6: result
   logic    s5_valid_ff;
   logic    s5_in_frame_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   assign rsp_in.pixel_out = s5_in_frame_ff ? (ram_rd_data & pix_mask) : pix_mask;
   assign rsp_in.is_fill   = !s5_in_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff  <= s4_valid_ff && (s4_op_ff == OP_READ);
         rsp_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_in_frame_ff <= in_frame;
      rsp_ff         <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/nnir_checker.sv
// Port-level assertions of the nearest neighbor image rotator and their bind.
`include "nearest_neighbor_image_rotator_macros.svh"

module nnir_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input nnir_pkg::req_type req_payload,
   input logic              rsp_valid,
   input nnir_pkg::rsp_type rsp_payload
);

   import nnir_pkg::*;

   logic rd_xfer;
   logic wr_xfer;
   logic fill_ok;

   assign rd_xfer = start && !busy && (req_payload.opcode == OP_READ);
   assign wr_xfer = start && !busy && (req_payload.opcode == OP_WRITE);
   assign fill_ok = !(rsp_valid && rsp_payload.is_fill)
                 || rsp_payload.pixel_out == WHITE_8 || rsp_payload.pixel_out == WHITE_24;

   `NNIR_ASSERT_IMPL(a_read_gives_result, clock, reset, rd_xfer, ##RSP_LATENCY rsp_valid)
   `NNIR_ASSERT_IMPL(a_write_gives_none, clock, reset, wr_xfer, ##RSP_LATENCY !rsp_valid)
   `NNIR_ASSERT_IMPL(a_idle_gives_none, clock, reset, !(start && !busy), ##RSP_LATENCY !rsp_valid)
   `NNIR_ASSERT_ALWAYS(a_fill_is_white, clock, reset, fill_ok)

endmodule

bind nearest_neighbor_image_rotator nnir_checker u_nnir_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_payload (rsp_payload)
);
